[rtl/core/rwh_pkg.sv]
// Shared constants and types for the random-walk height grid generator.
`default_nettype none

package rwh_pkg;

    // Line buffer depth default
    localparam int MAX_ROW_CELLS_DEF = 4096;

    // Field widths
    localparam int HEIGHT_W  = 8;
    localparam int OFFSET_W  = 4;
    localparam int ROW_LEN_W = 13;
    localparam int ROW_CNT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [HEIGHT_W-1:0]  START_HEIGHT_RST = 8'd140;
    localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST   = 13'd3600;
    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST    = 16'd3600;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_HEIGHT = 2'd0,
        CFG_ROW_LENGTH   = 2'd1,
        CFG_ROW_COUNT    = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

[rtl/core/random_walk_heightmap.sv]
// Top level of the random-walk height grid generator.
`default_nettype none

// Produces a grid of 8-bit heights in raster order, one cell per input
// transfer on s_*, each result leaving on m_* with row_end and grid_end
// flags. A result appears in the cycle after its input transfer; the single
// output register decouples the two sides, so a new offset is taken every
// clock cycle in which the output register is empty or is being drained. The
// previous row lives in a line buffer of MAX_ROW_CELLS entries whose read
// is issued ahead for the next column, so no extra latency is added.
// Registers may be written over cfg_* only while no cell is in flight;
// row_length above MAX_ROW_CELLS acts as MAX_ROW_CELLS, and zero lengths
// or counts act as 1.
module random_walk_heightmap #(
    parameter int MAX_ROW_CELLS = rwh_pkg::MAX_ROW_CELLS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rwh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rwh_pkg::CFG_DATA_W-1:0]    cfg_data,
    // offsets in
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [rwh_pkg::OFFSET_W-1:0] s_offset,
    // heights out
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [rwh_pkg::HEIGHT_W-1:0]           m_cell_height,
    output logic                                   m_row_end,
    output logic                                   m_grid_end
);

    import rwh_pkg::*;

    localparam int CW    = $clog2(MAX_ROW_CELLS);
    localparam int CNT_W = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;

    // Configuration registers
    logic [HEIGHT_W-1:0]  start_height_reg;
    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [ROW_CNT_W-1:0] row_count_reg;

    // Walk state
    logic [HEIGHT_W-1:0]  left_height_reg;
    logic [HEIGHT_W-1:0]  first_height_reg;
    logic [ROW_CNT_W-1:0] row_pos_reg;
    logic [CW-1:0]        col_pos_reg;

    // Output register
    logic                 m_valid_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic                 row_end_reg;
    logic                 grid_end_reg;

    logic                 accept;
    logic [CNT_W-1:0]     len_raw;
    logic [CNT_W-1:0]     len_eff;
    logic [ROW_CNT_W:0]   cnt_eff;
    logic [CNT_W-1:0]     col_plus;
    logic [ROW_CNT_W:0]   row_plus;
    logic                 row_end;
    logic                 grid_end;
    logic [CW-1:0]        col_next;
    logic [ROW_CNT_W-1:0] row_next;
    logic [CW-1:0]        rd_addr;
    logic [HEIGHT_W-1:0]  up_height;
    logic [HEIGHT_W:0]    pair_sum;
    logic [HEIGHT_W-1:0]  base_height;
    logic signed [HEIGHT_W+1:0] walk_sum;
    logic [HEIGHT_W-1:0]  clamped;
    logic [HEIGHT_W-1:0]  height_next;
    logic                 first_row;
    logic                 first_col;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_height_reg <= START_HEIGHT_RST;
            row_length_reg   <= ROW_LENGTH_RST;
            row_count_reg    <= ROW_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_HEIGHT: start_height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_ROW_LENGTH:   row_length_reg   <= cfg_data[ROW_LEN_W-1:0];
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data[ROW_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective limits
    always_comb begin
        len_raw = CNT_W'(row_length_reg);
        if (len_raw == '0) begin
            len_eff = CNT_W'(1);
        end else if (len_raw > CNT_W'(MAX_ROW_CELLS)) begin
            len_eff = CNT_W'(MAX_ROW_CELLS);
        end else begin
            len_eff = len_raw;
        end
        cnt_eff = (row_count_reg == '0) ? (ROW_CNT_W+1)'(1) : {1'b0, row_count_reg};
    end

    assign col_plus = CNT_W'(col_pos_reg) + CNT_W'(1);
    assign row_plus = {1'b0, row_pos_reg} + (ROW_CNT_W+1)'(1);
    assign row_end  = (col_plus >= len_eff);
    assign grid_end = row_end && (row_plus >= cnt_eff);
    assign col_next = row_end ? '0 : col_plus[CW-1:0];
    assign row_next = grid_end ? '0 : row_plus[ROW_CNT_W-1:0];

    // Read ahead for the column that the next transfer will use
    assign rd_addr = accept ? col_next : col_pos_reg;

    rwh_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (MAX_ROW_CELLS)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_pos_reg),
        .wr_data (height_next),
        .rd_addr (rd_addr),
        .rd_data (up_height)
    );

    assign first_row = (row_pos_reg == '0);
    assign first_col = (col_pos_reg == '0);

    always_comb begin
        pair_sum = {1'b0, left_height_reg} + {1'b0, up_height};
        if (first_row) begin
            base_height = left_height_reg;
        end else if (first_col) begin
            base_height = first_height_reg;
        end else begin
            base_height = pair_sum[HEIGHT_W:1];
        end
        walk_sum = $signed({2'b00, base_height}) + (HEIGHT_W+2)'(s_offset);
        if (walk_sum < 0) begin
            clamped = '0;
        end else if (walk_sum > $signed({2'b00, HEIGHT_MAX})) begin
            clamped = HEIGHT_MAX;
        end else begin
            clamped = walk_sum[HEIGHT_W-1:0];
        end
        height_next = (first_row && first_col) ? start_height_reg : clamped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_height_reg <= '0;
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
        end else if (accept) begin
            left_height_reg <= height_next;
            row_pos_reg     <= row_end ? row_next : row_pos_reg;
            col_pos_reg     <= col_next;
        end
    end

    // Height of the first cell of the row above
    always_ff @(posedge aclk) begin
        if (accept && first_col) begin
            first_height_reg <= height_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            height_reg   <= height_next;
            row_end_reg  <= row_end;
            grid_end_reg <= grid_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cell_height = height_reg;
    assign m_row_end     = row_end_reg;
    assign m_grid_end    = grid_end_reg;

endmodule

`default_nettype wire

[rtl/core/rwh_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
